// File: sv/ddo_pkg.sv
// Shared types, constants and tables of the differential-drive odometry unit.
`default_nettype none
package ddo_pkg;

    localparam int CORDIC_STEPS_DEF = 24;
    localparam int FRAC_BITS        = 16;
    localparam int STEP_SHIFT       = FRAC_BITS + 17;
    localparam int HALF_SHIFT       = FRAC_BITS + 18;

    localparam logic [30:0] INV_PI_Q32      = 31'd1367130551;
    localparam logic [33:0] CORDIC_GAIN_Q30 = 34'd652032874;
    localparam logic [15:0] TRACK_RESET     = 16'd160;

    localparam logic [1:0] SIDE_LEFT  = 2'd1;
    localparam logic [1:0] SIDE_RIGHT = 2'd2;

    localparam int DIV_NUM_W = 64;
    localparam int DIV_DEN_W = 48;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

    // arctan(2^-i) as binary angle, full turn = 2^32
    localparam logic [31:0] ATAN_BAM [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    typedef enum logic [4:0] {
        ST_IDLE, ST_SUMDIFF, ST_MUL_TRAV, ST_DIV_T, ST_WAIT_T, ST_MUL_TLO, ST_MUL_THI,
        ST_ACC_T, ST_STEP, ST_HALF, ST_COR_POSE, ST_WAIT_POSE, ST_MUL_X, ST_MUL_Y,
        ST_ACC_Y, ST_VEL, ST_MUL_LIN, ST_DIV_LIN, ST_WAIT_LIN, ST_MUL_ANG, ST_MUL_DEN,
        ST_DIV_ANG, ST_WAIT_ANG, ST_COR_QUAT, ST_WAIT_QUAT, ST_LOAD
    } ddo_state_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_ACCEPT, OP_SUMDIFF, OP_MUL_TRAV, OP_DIV_T, OP_TAKE_T, OP_MUL_TLO,
        OP_MUL_THI, OP_ACC_T, OP_STEP, OP_HALF, OP_COR_POSE, OP_TAKE_CS, OP_MUL_X,
        OP_MUL_Y, OP_ACC_Y, OP_VEL_ZERO, OP_MUL_LIN, OP_DIV_LIN, OP_TAKE_LIN,
        OP_MUL_ANG, OP_MUL_DEN, OP_DIV_ANG, OP_TAKE_ANG, OP_COR_QUAT, OP_TAKE_QUAT,
        OP_LOAD
    } ddo_op_t;

    typedef struct packed {
        logic pair;
        logic div_done;
        logic cor_done;
        logic vel_ok;
        logic out_free;
    } ddo_status_t;

endpackage
`default_nettype wire

// File: sv/ddo_divider.sv
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none
module ddo_divider (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [ddo_pkg::DIV_NUM_W-1:0] num,
    input  wire logic [ddo_pkg::DIV_DEN_W-1:0] den,
    output logic                               done,
    output logic [ddo_pkg::DIV_NUM_W-1:0]      quot
);
    import ddo_pkg::*;

    localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(DIV_NUM_W - 1);

    logic [DIV_DEN_W-1:0] rem_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_NUM_W-1:0] quo_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_DEN_W:0]   trial;
    logic                 ge;

    assign trial = {rem_reg, quo_reg[DIV_NUM_W-1]};
    assign ge    = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            den_reg <= den;
            quo_reg <= num;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? DIV_DEN_W'(trial - {1'b0, den_reg}) : trial[DIV_DEN_W-1:0];
            quo_reg <= {quo_reg[DIV_NUM_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;
endmodule
`default_nettype wire

// File: sv/ddo_cordic.sv
// Iterative rotation-mode CORDIC giving cosine and sine of a binary angle.
`default_nettype none
module ddo_cordic #(
    parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [31:0]        angle,
    output logic                    done,
    output logic signed [33:0]      cos_out,
    output logic signed [33:0]      sin_out
);
    import ddo_pkg::*;

    localparam int CW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam logic [CW-1:0] I_LAST = CW'(CORDIC_STEPS - 1);

    logic signed [33:0] x_reg, y_reg, z_reg;
    logic [CW-1:0]      i_reg;
    logic               flip_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [31:0]        quarter_chk;
    logic [31:0]        ang_fold;
    logic signed [33:0] atan_cur;

    assign quarter_chk = angle + 32'h4000_0000;
    assign ang_fold    = quarter_chk[31] ? angle + 32'h8000_0000 : angle;
    assign atan_cur    = $signed({2'b00, ATAN_BAM[5'(i_reg)]});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                i_reg    <= '0;
            end
            else if (busy_reg)
            begin
                i_reg <= i_reg + 1'b1;
                if (i_reg == I_LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= $signed(CORDIC_GAIN_Q30);
            y_reg    <= '0;
            z_reg    <= $signed({{2{ang_fold[31]}}, ang_fold});
            flip_reg <= quarter_chk[31];
        end
        else if (busy_reg)
        begin
            if (!z_reg[33])
            begin
                x_reg <= x_reg - (y_reg >>> i_reg);
                y_reg <= y_reg + (x_reg >>> i_reg);
                z_reg <= z_reg - atan_cur;
            end
            else
            begin
                x_reg <= x_reg + (y_reg >>> i_reg);
                y_reg <= y_reg - (x_reg >>> i_reg);
                z_reg <= z_reg + atan_cur;
            end
        end
    end

    assign done    = done_reg;
    assign cos_out = flip_reg ? -x_reg : x_reg;
    assign sin_out = flip_reg ? -y_reg : y_reg;
endmodule
`default_nettype wire

// File: sv/ddo_ctrl.sv
// Sequencer of the odometry update: one datapath command per state.
`default_nettype none
module ddo_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 wheel_valid,
    output logic                      wheel_stall,
    input  wire ddo_pkg::ddo_status_t status,
    output ddo_pkg::ddo_op_t          op
);
    import ddo_pkg::*;

    ddo_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        op          = OP_NONE;
        wheel_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                wheel_stall = 1'b0;
                if (wheel_valid)
                begin
                    op = OP_ACCEPT;
                    if (status.pair)
                        state_next = ST_SUMDIFF;
                end
            end
            ST_SUMDIFF:   begin op = OP_SUMDIFF;  state_next = ST_MUL_TRAV; end
            ST_MUL_TRAV:  begin op = OP_MUL_TRAV; state_next = ST_DIV_T;    end
            ST_DIV_T:     begin op = OP_DIV_T;    state_next = ST_WAIT_T;   end
            ST_WAIT_T:
            begin
                if (status.div_done)
                begin
                    op         = OP_TAKE_T;
                    state_next = ST_MUL_TLO;
                end
            end
            ST_MUL_TLO:   begin op = OP_MUL_TLO;  state_next = ST_MUL_THI;  end
            ST_MUL_THI:   begin op = OP_MUL_THI;  state_next = ST_ACC_T;    end
            ST_ACC_T:     begin op = OP_ACC_T;    state_next = ST_STEP;     end
            ST_STEP:      begin op = OP_STEP;     state_next = ST_HALF;     end
            ST_HALF:      begin op = OP_HALF;     state_next = ST_COR_POSE; end
            ST_COR_POSE:  begin op = OP_COR_POSE; state_next = ST_WAIT_POSE; end
            ST_WAIT_POSE:
            begin
                if (status.cor_done)
                begin
                    op         = OP_TAKE_CS;
                    state_next = ST_MUL_X;
                end
            end
            ST_MUL_X:     begin op = OP_MUL_X;    state_next = ST_MUL_Y;    end
            ST_MUL_Y:     begin op = OP_MUL_Y;    state_next = ST_ACC_Y;    end
            ST_ACC_Y:     begin op = OP_ACC_Y;    state_next = ST_VEL;      end
            ST_VEL:
            begin
                if (status.vel_ok)
                    state_next = ST_MUL_LIN;
                else
                begin
                    op         = OP_VEL_ZERO;
                    state_next = ST_COR_QUAT;
                end
            end
            ST_MUL_LIN:   begin op = OP_MUL_LIN;  state_next = ST_DIV_LIN;  end
            ST_DIV_LIN:   begin op = OP_DIV_LIN;  state_next = ST_WAIT_LIN; end
            ST_WAIT_LIN:
            begin
                if (status.div_done)
                begin
                    op         = OP_TAKE_LIN;
                    state_next = ST_MUL_ANG;
                end
            end
            ST_MUL_ANG:   begin op = OP_MUL_ANG;  state_next = ST_MUL_DEN;  end
            ST_MUL_DEN:   begin op = OP_MUL_DEN;  state_next = ST_DIV_ANG;  end
            ST_DIV_ANG:   begin op = OP_DIV_ANG;  state_next = ST_WAIT_ANG; end
            ST_WAIT_ANG:
            begin
                if (status.div_done)
                begin
                    op         = OP_TAKE_ANG;
                    state_next = ST_COR_QUAT;
                end
            end
            ST_COR_QUAT:  begin op = OP_COR_QUAT; state_next = ST_WAIT_QUAT; end
            ST_WAIT_QUAT:
            begin
                if (status.cor_done)
                begin
                    op         = OP_TAKE_QUAT;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (status.out_free)
                begin
                    op         = OP_LOAD;
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

// File: sv/ddo_datapath.sv
// Odometry datapath: wheel holding registers, pose state, shared multiplier,
// divider and CORDIC, and the output word register.
`default_nettype none
module ddo_datapath #(
    parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 wheel_track_we,
    input  wire logic [15:0]          wheel_track_mm,
    input  wire logic [1:0]           wheel_side,
    input  wire logic signed [31:0]   wheel_distance,
    input  wire logic [31:0]          timestamp_us,
    input  wire logic                 pose_stall,
    input  wire ddo_pkg::ddo_op_t     op,
    output ddo_pkg::ddo_status_t      status,
    output logic                      pose_valid,
    output logic signed [31:0]        pos_x,
    output logic signed [31:0]        pos_y,
    output logic [31:0]               heading,
    output logic signed [31:0]        quat_z,
    output logic signed [31:0]        quat_w,
    output logic signed [31:0]        linear_velocity,
    output logic signed [31:0]        yaw_rate
);
    import ddo_pkg::*;

    function automatic logic signed [31:0] acc_sat(input logic signed [31:0] acc,
                                                   input logic signed [66:0] prod);
        logic signed [66:0] rnd;
        logic signed [67:0] tot;
        rnd = (prod + 67'sd1073741824) >>> 31;
        tot = 68'(acc) + 68'(rnd);
        if (tot > 68'sd2147483647)
            return 32'sh7fff_ffff;
        else if (tot < -68'sd2147483648)
            return 32'sh8000_0000;
        else
            return tot[31:0];
    endfunction

    function automatic logic signed [31:0] q_sat(input logic signed [33:0] v);
        if (v > 34'sd2147483647)
            return 32'sh7fff_ffff;
        else if (v < -34'sd2147483648)
            return 32'sh8000_0000;
        else
            return v[31:0];
    endfunction

    function automatic logic [31:0] mag_sat(input logic neg, input logic [63:0] q);
        if (!neg)
            return (q > 64'd2147483647) ? 32'h7fff_ffff : q[31:0];
        else
            return (q > 64'd2147483648) ? 32'h8000_0000 : 32'd0 - q[31:0];
    endfunction

    logic [15:0]        track_reg;
    logic [15:0]        track_eff;
    logic signed [31:0] left_reg, right_reg;
    logic               left_seen_reg, right_seen_reg;
    logic [31:0]        now_reg;
    logic signed [31:0] x_reg, y_reg;
    logic [31:0]        heading_reg;
    logic [31:0]        last_time_reg;
    logic               time_known_reg;

    logic signed [32:0] sum_reg, diff_reg;
    logic [32:0]        diff_mag;
    logic [57:0]        t_reg;
    logic [89:0]        pacc_reg;
    logic [31:0]        step_reg, half_reg;
    logic signed [33:0] c_reg, s_reg;
    logic signed [66:0] mul_reg;
    logic [63:0]        num_hold_reg;
    logic               lin_neg_reg;
    logic signed [31:0] lin_reg, ang_reg;

    logic               pose_valid_reg;
    logic signed [31:0] pos_x_reg, pos_y_reg, quat_z_reg, quat_w_reg;
    logic signed [31:0] lin_out_reg, ang_out_reg;
    logic [31:0]        heading_out_reg;

    logic signed [33:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [66:0] prod;
    logic [66:0]        mul_abs;
    logic [31:0]        dt;
    logic [90:0]        step_rnd, half_rnd;
    logic [31:0]        step_mag, half_mag;

    logic                 div_start, div_done;
    logic [DIV_NUM_W-1:0] div_num, div_quot;
    logic [DIV_DEN_W-1:0] div_den;
    logic                 cor_start, cor_done;
    logic [31:0]          cor_angle;
    logic signed [33:0]   cor_cos, cor_sin;

    assign track_eff = (track_reg == 16'd0) ? 16'd1 : track_reg;
    assign diff_mag  = diff_reg[32] ? 33'(-diff_reg) : diff_reg;
    assign mul_abs   = mul_reg[66] ? 67'(-mul_reg) : mul_reg;
    assign dt        = now_reg - last_time_reg;

    assign step_rnd = {1'b0, pacc_reg} + (91'(1) << (STEP_SHIFT - 1));
    assign half_rnd = {1'b0, pacc_reg} + (91'(1) << (HALF_SHIFT - 1));
    assign step_mag = 32'(step_rnd >> STEP_SHIFT);
    assign half_mag = 32'(half_rnd >> HALF_SHIFT);

    assign status.pair     = (wheel_side == SIDE_LEFT  || left_seen_reg) &&
                             (wheel_side == SIDE_RIGHT || right_seen_reg);
    assign status.div_done = div_done;
    assign status.cor_done = cor_done;
    assign status.vel_ok   = time_known_reg && (dt != 32'd0);
    assign status.out_free = !pose_valid_reg || !pose_stall;

    // operand select for the one shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (op)
            OP_MUL_TRAV:
            begin
                mul_a = $signed({1'b0, diff_mag});
                mul_b = 33'sd1000;
            end
            OP_MUL_TLO:
            begin
                mul_a = $signed({2'b00, t_reg[31:0]});
                mul_b = $signed({2'b00, INV_PI_Q32});
            end
            OP_MUL_THI:
            begin
                mul_a = $signed({8'd0, t_reg[57:32]});
                mul_b = $signed({2'b00, INV_PI_Q32});
            end
            OP_MUL_X:
            begin
                mul_a = 34'(sum_reg);
                mul_b = c_reg[32:0];
            end
            OP_MUL_Y:
            begin
                mul_a = 34'(sum_reg);
                mul_b = s_reg[32:0];
            end
            OP_MUL_LIN:
            begin
                mul_a = 34'(sum_reg);
                mul_b = 33'sd1000000;
            end
            OP_MUL_ANG:
            begin
                mul_a = 34'(diff_reg);
                mul_b = 33'sd1000000000;
            end
            OP_MUL_DEN:
            begin
                mul_a = $signed({2'b00, dt});
                mul_b = $signed({17'd0, track_eff});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    always_comb
    begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        case (op)
            OP_DIV_T:
            begin
                div_start = 1'b1;
                div_num   = {6'd0, mul_reg[41:0], 16'd0};
                div_den   = DIV_DEN_W'(track_eff);
            end
            OP_DIV_LIN:
            begin
                div_start = 1'b1;
                div_num   = mul_abs[63:0];
                div_den   = DIV_DEN_W'({dt, 1'b0});
            end
            OP_DIV_ANG:
            begin
                div_start = 1'b1;
                div_num   = num_hold_reg;
                div_den   = mul_reg[DIV_DEN_W-1:0];
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    assign cor_start = (op == OP_COR_POSE) || (op == OP_COR_QUAT);
    assign cor_angle = (op == OP_COR_QUAT) ? {1'b0, heading_reg[31:1]}
                                           : heading_reg + half_reg;

    // state that reset defines
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            track_reg      <= TRACK_RESET;
            left_reg       <= '0;
            right_reg      <= '0;
            left_seen_reg  <= 1'b0;
            right_seen_reg <= 1'b0;
            x_reg          <= '0;
            y_reg          <= '0;
            heading_reg    <= '0;
            last_time_reg  <= '0;
            time_known_reg <= 1'b0;
            pose_valid_reg <= 1'b0;
        end
        else
        begin
            if (wheel_track_we)
                track_reg <= wheel_track_mm;
            if (op == OP_LOAD)
                pose_valid_reg <= 1'b1;
            else if (pose_valid_reg && !pose_stall)
                pose_valid_reg <= 1'b0;
            case (op)
                OP_ACCEPT:
                begin
                    if (wheel_side == SIDE_LEFT)
                        left_reg <= wheel_distance;
                    if (wheel_side == SIDE_RIGHT)
                        right_reg <= wheel_distance;
                    // a completed pair drops both flags
                    if (status.pair)
                    begin
                        left_seen_reg  <= 1'b0;
                        right_seen_reg <= 1'b0;
                    end
                    else
                    begin
                        if (wheel_side == SIDE_LEFT)
                            left_seen_reg <= 1'b1;
                        if (wheel_side == SIDE_RIGHT)
                            right_seen_reg <= 1'b1;
                    end
                end
                OP_MUL_Y:    x_reg <= acc_sat(x_reg, mul_reg);
                OP_ACC_Y:
                begin
                    y_reg       <= acc_sat(y_reg, mul_reg);
                    heading_reg <= heading_reg + step_reg;
                end
                OP_COR_QUAT:
                begin
                    last_time_reg  <= now_reg;
                    time_known_reg <= 1'b1;
                end
                default:     ;
            endcase
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (op inside {OP_MUL_TRAV, OP_MUL_TLO, OP_MUL_THI, OP_MUL_X, OP_MUL_Y,
                       OP_MUL_LIN, OP_MUL_ANG, OP_MUL_DEN})
            mul_reg <= prod;
        case (op)
            OP_ACCEPT:   now_reg <= timestamp_us;
            OP_SUMDIFF:
            begin
                sum_reg  <= 33'(right_reg) + 33'(left_reg);
                diff_reg <= 33'(right_reg) - 33'(left_reg);
            end
            OP_TAKE_T:   t_reg <= div_quot[57:0];
            OP_MUL_THI:  pacc_reg <= 90'(mul_reg[62:0]);
            OP_ACC_T:    pacc_reg <= pacc_reg + (90'(mul_reg[57:0]) << 32);
            OP_STEP:     step_reg <= diff_reg[32] ? 32'd0 - step_mag : step_mag;
            OP_HALF:     half_reg <= diff_reg[32] ? 32'd0 - half_mag : half_mag;
            OP_TAKE_CS, OP_TAKE_QUAT:
            begin
                c_reg <= cor_cos;
                s_reg <= cor_sin;
            end
            OP_VEL_ZERO:
            begin
                lin_reg <= '0;
                ang_reg <= '0;
            end
            OP_DIV_LIN:  lin_neg_reg <= mul_reg[66];
            OP_TAKE_LIN: lin_reg <= $signed(mag_sat(lin_neg_reg, div_quot));
            OP_MUL_DEN:  num_hold_reg <= mul_abs[63:0];
            OP_TAKE_ANG: ang_reg <= $signed(mag_sat(diff_reg[32], div_quot));
            OP_LOAD:
            begin
                pos_x_reg       <= x_reg;
                pos_y_reg       <= y_reg;
                heading_out_reg <= heading_reg;
                quat_z_reg      <= q_sat(s_reg);
                quat_w_reg      <= q_sat(c_reg);
                lin_out_reg     <= lin_reg;
                ang_out_reg     <= ang_reg;
            end
            default:     ;
        endcase
    end

    ddo_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    ddo_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cor_start),
        .angle   (cor_angle),
        .done    (cor_done),
        .cos_out (cor_cos),
        .sin_out (cor_sin)
    );

    assign pose_valid       = pose_valid_reg;
    assign pos_x            = pos_x_reg;
    assign pos_y            = pos_y_reg;
    assign heading          = heading_out_reg;
    assign quat_z           = quat_z_reg;
    assign quat_w           = quat_w_reg;
    assign linear_velocity  = lin_out_reg;
    assign yaw_rate         = ang_out_reg;
endmodule
`default_nettype wire

// File: sv/diff_drive_odometry_unit.sv
// Top level of the differential-drive wheel odometry unit.
`default_nettype none
// Wheel reports (side, Q16.16 travel, microsecond timestamp) come in one word
// at a time on the wheel channel; a report for side 0 or 3 is taken and
// dropped, and a lone left or right report is taken and held.
// When a report completes a left/right pair the unit runs its update and
// holds off new wheel words until the pose word is loaded into the output
// register; the load also waits while an earlier pose word is still stalled.
// The update runs the bit-serial divider once for the turn angle and, when
// velocities are computed, once each for linear and angular velocity, and
// runs the iterative CORDIC for the travel direction and for the
// half-heading quaternion. Velocities are not computed on the first pair or
// when the timestamp has not moved. A finished pose word waits in the
// output register while new wheel words are taken. Write wheel_track_mm only
// while the unit is idle; a value of zero is treated as one millimetre.
module diff_drive_odometry_unit #(
    parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // configuration
    input  wire logic               wheel_track_we,
    input  wire logic [15:0]        wheel_track_mm,
    // wheel report channel
    input  wire logic               wheel_valid,
    output logic                    wheel_stall,
    input  wire logic [1:0]         wheel_side,
    input  wire logic signed [31:0] wheel_distance,
    input  wire logic [31:0]        timestamp_us,
    // pose channel
    output logic                    pose_valid,
    input  wire logic               pose_stall,
    output logic signed [31:0]      pos_x,
    output logic signed [31:0]      pos_y,
    output logic [31:0]             heading,
    output logic signed [31:0]      quat_z,
    output logic signed [31:0]      quat_w,
    output logic signed [31:0]      linear_velocity,
    output logic signed [31:0]      yaw_rate
);
    import ddo_pkg::*;

    ddo_op_t     op;
    ddo_status_t status;

    // sequencer: one command to the datapath per cycle
    ddo_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .wheel_valid (wheel_valid),
        .wheel_stall (wheel_stall),
        .status      (status),
        .op          (op)
    );

    // datapath: pose state, arithmetic units and output word register
    ddo_datapath #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .wheel_track_we   (wheel_track_we),
        .wheel_track_mm   (wheel_track_mm),
        .wheel_side       (wheel_side),
        .wheel_distance   (wheel_distance),
        .timestamp_us     (timestamp_us),
        .pose_stall       (pose_stall),
        .op               (op),
        .status           (status),
        .pose_valid       (pose_valid),
        .pos_x            (pos_x),
        .pos_y            (pos_y),
        .heading          (heading),
        .quat_z           (quat_z),
        .quat_w           (quat_w),
        .linear_velocity  (linear_velocity),
        .yaw_rate         (yaw_rate)
    );
endmodule
`default_nettype wire

// File: sv/ddo_checker.sv
// Port-level assertions for the odometry unit and their bind to the top level.
`default_nettype none
module ddo_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        wheel_valid,
    input wire logic        wheel_stall,
    input wire logic [1:0]  wheel_side,
    input wire logic        pose_valid,
    input wire logic        pose_stall,
    input wire logic [31:0] pos_x,
    input wire logic [31:0] heading
);
    import ddo_pkg::*;

    logic wheel_acc;
    assign wheel_acc = wheel_valid && !wheel_stall;

    // a stalled pose word holds
    a_pose_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pose_valid && pose_stall |=> pose_valid && $stable(pos_x) && $stable(heading))
        else $error("pose word changed while stalled");

    // an ignored side never starts an update
    a_ignored_side: assert property (@(posedge clk) disable iff (!rst_n)
        wheel_acc && wheel_side != SIDE_LEFT && wheel_side != SIDE_RIGHT |=> !wheel_stall)
        else $error("ignored wheel word started an update");

    // left then right back to back completes a pair
    a_pair_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (wheel_acc && wheel_side == SIDE_LEFT) ##1 (wheel_acc && wheel_side == SIDE_RIGHT)
        |=> wheel_stall)
        else $error("completed pair did not start an update");

    // a pose word appears only at the end of an update
    a_pose_from_update: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pose_valid) |-> $past(wheel_stall))
        else $error("pose word appeared outside an update");
endmodule

bind diff_drive_odometry_unit ddo_checker u_ddo_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .wheel_valid (wheel_valid),
    .wheel_stall (wheel_stall),
    .wheel_side  (wheel_side),
    .pose_valid  (pose_valid),
    .pose_stall  (pose_stall),
    .pos_x       (pos_x),
    .heading     (heading)
);
`default_nettype wire

// File: dv/tb_diff_drive_odometry_unit.sv
// Testbench for the differential-drive wheel odometry unit: random and directed checks.
`timescale 1ns / 1ps
module tb_diff_drive_odometry_unit;
    import ddo_pkg::*;

    localparam int STEPS      = 24;
    // settle time after the last pose word; covers the slowest update with a margin
    localparam int SETTLE     = 400;
    localparam int WATCHDOG   = 20000;
    localparam longint S32MAX = 64'sd2147483647;
    localparam longint S32MIN = -64'sd2147483648;

    typedef struct {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] heading;
        logic [31:0] quat_z;
        logic [31:0] quat_w;
        logic [31:0] lin_vel;
        logic [31:0] ang_vel;
    } pose_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic wheel_track_we = 1'b0;
    logic [15:0] wheel_track_mm = 16'd0;
    logic wheel_valid = 1'b0;
    logic wheel_stall;
    logic [1:0] wheel_side = 2'd0;
    logic signed [31:0] wheel_distance = 32'sd0;
    logic [31:0] timestamp_us = 32'd0;
    logic pose_valid;
    logic pose_stall = 1'b0;
    logic signed [31:0] pos_x, pos_y, quat_z, quat_w, linear_velocity, yaw_rate;
    logic [31:0] heading;

    diff_drive_odometry_unit #(.CORDIC_STEPS(STEPS)) dut (
        .clk(clk), .rst_n(rst_n),
        .wheel_track_we(wheel_track_we), .wheel_track_mm(wheel_track_mm),
        .wheel_valid(wheel_valid), .wheel_stall(wheel_stall),
        .wheel_side(wheel_side), .wheel_distance(wheel_distance),
        .timestamp_us(timestamp_us),
        .pose_valid(pose_valid), .pose_stall(pose_stall),
        .pos_x(pos_x), .pos_y(pos_y), .heading(heading),
        .quat_z(quat_z), .quat_w(quat_w),
        .linear_velocity(linear_velocity), .yaw_rate(yaw_rate)
    );

    // odometry state mirrored in the testbench
    logic [15:0] track_mm;
    longint left_travel, right_travel;
    bit left_held, right_held;
    longint x_pos, y_pos;
    logic [31:0] head_bam, last_stamp;
    bit stamp_known;

    pose_word_t pending_poses[$];
    bit failed = 1'b0;
    int idle_pct = 0;        // sender gap chance per cycle, percent
    int stall_pct = 0;       // receiver stall chance per cycle, percent
    int hold_count = 0;      // long receiver hold-off, counted by the stall process
    int quiet_cycles = 0;
    logic [31:0] clock_us = 32'd0;

    initial
    begin
        forever #10 clk = ~clk;
    end

    // saturate to the signed 32-bit range
    function automatic longint clamp32(longint v);
        if (v > S32MAX)
            return S32MAX;
        if (v < S32MIN)
            return S32MIN;
        return v;
    endfunction

    // rotation-mode sine/cosine of a binary angle, Q1.30
    task automatic rotate_bam(input logic [31:0] ang, output longint c, output longint s);
        bit flip;
        longint x, y, z, nx;
        logic [31:0] a;
        a = ang;
        flip = 1'b0;
        if (((a + 32'h4000_0000) & 32'h8000_0000) != 0)
        begin
            a = a + 32'h8000_0000;
            flip = 1'b1;
        end
        x = longint'(CORDIC_GAIN_Q30);
        y = 0;
        z = longint'(signed'(a));
        for (int i = 0; i < STEPS; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z = z - longint'(ATAN_BAM[i]);
            end
            else
            begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z = z + longint'(ATAN_BAM[i]);
            end
            x = nx;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    // low 32 bits of round(t * 2^32/pi / 2^sh)
    function automatic logic [31:0] scale_turn(logic [63:0] t, int sh);
        logic [127:0] p;
        p = 128'(t) * 128'(INV_PI_Q32) + (128'd1 << (sh - 1));
        return 32'(p >> sh);
    endfunction

    // truncating signed divide with saturation
    function automatic longint div_sat(longint num, logic [63:0] den);
        logic [63:0] mag;
        longint q;
        mag = num < 0 ? 64'(-num) : 64'(num);
        q = longint'(mag / den);
        return clamp32(num < 0 ? -q : q);
    endfunction

    // apply one accepted wheel report; queue a pose word when a pair completes
    task automatic update_odometry(logic [1:0] side, logic [31:0] travel, logic [31:0] now);
        logic [63:0] trk, t, dt;
        logic [31:0] dt32;
        longint sum, diff, c, s, lin, ang;
        logic [31:0] step, half;
        pose_word_t w;
        if (side == SIDE_LEFT)
        begin
            left_travel = longint'(signed'(travel));
            left_held = 1'b1;
        end
        else if (side == SIDE_RIGHT)
        begin
            right_travel = longint'(signed'(travel));
            right_held = 1'b1;
        end
        if (!(left_held && right_held))
            return;
        left_held = 1'b0;
        right_held = 1'b0;
        trk = (track_mm == 0) ? 64'd1 : 64'(track_mm);
        sum = right_travel + left_travel;
        diff = right_travel - left_travel;
        t = (64'(diff < 0 ? -diff : diff) * 64'd1000 * 64'd65536) / trk;
        step = scale_turn(t, STEP_SHIFT);
        half = scale_turn(t, HALF_SHIFT);
        if (diff < 0)
        begin
            step = -step;
            half = -half;
        end
        rotate_bam(head_bam + half, c, s);
        x_pos = clamp32(x_pos + ((sum * c + (64'sd1 <<< 30)) >>> 31));
        y_pos = clamp32(y_pos + ((sum * s + (64'sd1 <<< 30)) >>> 31));
        head_bam = head_bam + step;
        dt32 = now - last_stamp;
        dt = 64'(dt32);
        lin = 0;
        ang = 0;
        if (stamp_known && dt != 0)
        begin
            lin = div_sat(sum * 1000000, 2 * dt);
            ang = div_sat(diff * 64'sd1000000000, trk * dt);
        end
        last_stamp = now;
        stamp_known = 1'b1;
        rotate_bam(head_bam >> 1, c, s);
        w.pos_x = x_pos[31:0];
        w.pos_y = y_pos[31:0];
        w.heading = head_bam;
        w.quat_z = 32'(clamp32(s));
        w.quat_w = 32'(clamp32(c));
        w.lin_vel = lin[31:0];
        w.ang_vel = ang[31:0];
        pending_poses.push_back(w);
    endtask

    // offer one wheel word, with random gaps ahead of it, and hold it until taken
    task automatic send_report(logic [1:0] side, logic [31:0] travel, logic [31:0] now);
        bit taken;
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            wheel_valid = 1'b0;
            @(negedge clk);
        end
        wheel_valid = 1'b1;
        wheel_side = side;
        wheel_distance = travel;
        timestamp_us = now;
        taken = 1'b0;
        while (!taken)
        begin
            @(posedge clk);
            if (!wheel_stall)
            begin
                taken = 1'b1;
                update_odometry(side, travel, now);
            end
            else
                @(negedge clk);
        end
    endtask

    // drop valid, wait for all pose words and let the unit go quiet
    task automatic drain();
        @(negedge clk);
        wheel_valid = 1'b0;
        while (pending_poses.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_track(logic [15:0] v);
        @(negedge clk);
        wheel_track_we = 1'b1;
        wheel_track_mm = v;
        @(negedge clk);
        wheel_track_we = 1'b0;
        track_mm = v;
    endtask

    task automatic send_pair(logic [31:0] l, logic [31:0] r, logic [31:0] now);
        send_report(SIDE_LEFT, l, now);
        send_report(SIDE_RIGHT, r, now);
    endtask

    // ignored sides, first output, turns, repeated side, equal and wrapped stamps
    task automatic test_special_cases();
        send_report(2'd0, 32'h7FFF_FFFF, 32'd5);
        send_report(2'd3, 32'h8000_0000, 32'd6);
        send_pair(32'h0001_0000, 32'h0001_0000, 32'd1000);
        send_pair(32'h0000_0000, 32'h0001_0000, 32'd2000);
        send_report(SIDE_RIGHT, 32'hFFFF_0000, 32'd2500);
        send_report(SIDE_LEFT, 32'h0000_8000, 32'd2600);
        send_report(SIDE_LEFT, 32'h0002_0000, 32'd2700);
        send_report(SIDE_RIGHT, 32'h0000_4000, 32'd2800);
        send_pair(32'h0000_1000, 32'hFFFF_F000, 32'd2800);
        send_pair(32'h0000_0100, 32'h0000_0300, 32'hFFFF_FF00);
        send_pair(32'h0000_0300, 32'h0000_0100, 32'h0000_0100);
        drain();
    endtask

    // field extremes: velocities and positions run into saturation
    task automatic test_extremes();
        send_pair(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0200);
        send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0201);
        send_pair(32'h8000_0000, 32'h8000_0000, 32'h0000_0202);
        for (int i = 0; i < 4; i++)
            send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0300 + i);
        send_pair(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        drain();
    endtask

    // track register at its extremes, including zero
    task automatic test_track_extremes();
        logic [15:0] settings[3] = '{16'd0, 16'd1, 16'hFFFF};
        foreach (settings[k])
        begin
            write_track(settings[k]);
            send_pair(32'h0000_0001, 32'hFFFF_FFFF, clock_us);
            send_pair(32'h0010_0000, 32'hFFF0_0000, clock_us + 32'd7);
            send_pair(32'h8000_0000, 32'h7FFF_FFFF, clock_us + 32'd9);
            clock_us = clock_us + 32'd100;
            drain();
        end
    endtask

    function automatic logic [31:0] pick_travel();
        case ($urandom_range(9))
            0: return $urandom();
            1: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            2, 3: return 32'(signed'(20'($urandom())));
            default: return 32'(signed'(17'($urandom())));
        endcase
    endfunction

    function automatic logic [31:0] next_stamp();
        case ($urandom_range(19))
            0: clock_us = $urandom();
            1: clock_us = clock_us;
            2: clock_us = 32'hFFFF_FFFF - $urandom_range(3000);
            default: clock_us = clock_us + $urandom_range(1, 20000);
        endcase
        return clock_us;
    endfunction

    // mostly well-formed left/right pairs with random content, some noise
    task automatic test_random_traffic(int items);
        int n;
        logic [1:0] side;
        n = 0;
        while (n < items)
        begin
            case ($urandom_range(19))
                0: side = $urandom_range(1) ? 2'd0 : 2'd3;
                1, 2: side = $urandom_range(1) ? SIDE_LEFT : SIDE_RIGHT;
                default:
                begin
                    side = SIDE_LEFT;
                    if ($urandom_range(1))
                    begin
                        send_report(SIDE_RIGHT, pick_travel(), next_stamp());
                        n++;
                    end
                    else
                    begin
                        send_report(SIDE_LEFT, pick_travel(), next_stamp());
                        n++;
                        side = SIDE_RIGHT;
                    end
                end
            endcase
            send_report(side, pick_travel(), next_stamp());
            if (side == SIDE_LEFT || side == SIDE_RIGHT)
                n++;
        end
        drain();
    endtask

    // hold the pose channel off long enough that the unit stalls its input
    task automatic test_backpressure();
        idle_pct = 0;
        stall_pct = 0;
        @(posedge clk);
        hold_count = 1500;
        for (int i = 0; i < 12; i++)
            send_pair(pick_travel(), pick_travel(), next_stamp());
        drain();
    endtask

    // receiver stall process; the long hold-off takes priority
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_count > 0)
            begin
                pose_stall = 1'b1;
                hold_count--;
            end
            else
                pose_stall = ($urandom_range(99) < stall_pct);
        end
    end

    // compare each taken pose word with the oldest expectation
    always @(posedge clk)
    begin
        pose_word_t w;
        if (rst_n && pose_valid && !pose_stall)
        begin
            if (pending_poses.size() == 0)
            begin
                $error("pose word with nothing expected");
                failed = 1'b1;
            end
            else
            begin
                w = pending_poses.pop_front();
                if (pos_x !== w.pos_x)
                begin
                    $error("pos_x exp %h got %h", w.pos_x, pos_x);
                    failed = 1'b1;
                end
                if (pos_y !== w.pos_y)
                begin
                    $error("pos_y exp %h got %h", w.pos_y, pos_y);
                    failed = 1'b1;
                end
                if (heading !== w.heading)
                begin
                    $error("heading exp %h got %h", w.heading, heading);
                    failed = 1'b1;
                end
                if (quat_z !== w.quat_z)
                begin
                    $error("quat_z exp %h got %h", w.quat_z, quat_z);
                    failed = 1'b1;
                end
                if (quat_w !== w.quat_w)
                begin
                    $error("quat_w exp %h got %h", w.quat_w, quat_w);
                    failed = 1'b1;
                end
                if (linear_velocity !== w.lin_vel)
                begin
                    $error("linear_velocity exp %h got %h", w.lin_vel, linear_velocity);
                    failed = 1'b1;
                end
                if (yaw_rate !== w.ang_vel)
                begin
                    $error("yaw_rate exp %h got %h", w.ang_vel, yaw_rate);
                    failed = 1'b1;
                end
            end
        end
    end

    // watchdog: end the run when no word moves on either channel for too long
    always @(posedge clk)
    begin
        if ((wheel_valid && !wheel_stall) || (pose_valid && !pose_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCHDOG)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        // mirror the reset state
        track_mm = TRACK_RESET;
        left_travel = 0;
        right_travel = 0;
        left_held = 1'b0;
        right_held = 1'b0;
        x_pos = 0;
        y_pos = 0;
        head_bam = 32'd0;
        last_stamp = 32'd0;
        stamp_known = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_special_cases();
        test_extremes();
        test_track_extremes();

        // random traffic over several track settings and idle phases
        write_track(TRACK_RESET);
        idle_pct = 0;
        stall_pct = 0;
        test_random_traffic(175);
        write_track($urandom_range(1, 65535));
        idle_pct = 48;
        stall_pct = 0;
        test_random_traffic(175);
        write_track($urandom_range(50, 600));
        idle_pct = 0;
        stall_pct = 48;
        test_random_traffic(175);
        write_track($urandom_range(1, 65535));
        idle_pct = 31;
        stall_pct = 31;
        test_random_traffic(175);

        test_backpressure();

        if (!failed && pending_poses.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

// File: diff_drive_odometry_unit.f
sv/ddo_pkg.sv
sv/ddo_divider.sv
sv/ddo_cordic.sv
sv/ddo_ctrl.sv
sv/ddo_datapath.sv
sv/diff_drive_odometry_unit.sv
sv/ddo_checker.sv
dv/tb_diff_drive_odometry_unit.sv
